FILE: hw/rtl/btlv_pkg.sv
package btlv_pkg;

   localparam int MAX_FIELDS_DEF      = 32;
   localparam int MAX_RELAY_COUNT_DEF = 16;
   localparam int PAYLOAD_BYTES_DEF   = 8192;
   localparam int KEY_BYTES           = 32;

   localparam int FIELD_OFFSET_W = 13;
   localparam int RQ_DEPTH       = 4;

   localparam logic [2:0] KIND_NOTE     = 3'd0;
   localparam logic [2:0] KIND_NPUB     = 3'd1;
   localparam logic [2:0] KIND_NSEC     = 3'd2;
   localparam logic [2:0] KIND_NPROFILE = 3'd3;
   localparam logic [2:0] KIND_NEVENT   = 3'd4;
   localparam logic [2:0] KIND_NRELAY   = 3'd5;
   localparam logic [2:0] KIND_NADDR    = 3'd6;
   localparam logic [2:0] KIND_UNKNOWN  = 3'd7;

   localparam logic [2:0] FK_EVENT_ID   = 3'd0;
   localparam logic [2:0] FK_PUBKEY     = 3'd1;
   localparam logic [2:0] FK_SECRET_KEY = 3'd2;
   localparam logic [2:0] FK_IDENTIFIER = 3'd3;
   localparam logic [2:0] FK_RELAY      = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_TRUNC   = 2'd1;
   localparam logic [1:0] ST_BAD_LEN = 2'd2;
   localparam logic [1:0] ST_MISSING = 2'd3;

   localparam logic RK_FIELD  = 1'b0;
   localparam logic RK_STATUS = 1'b1;

   localparam logic [7:0] TAG_PRIMARY = 8'd0;
   localparam logic [7:0] TAG_RELAY   = 8'd1;
   localparam logic [7:0] TAG_AUTHOR  = 8'd2;

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_LEN  = 2'd1,
      PH_VAL  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_item_type;

   typedef struct packed {
      logic                      result_kind;
      logic [2:0]                field_kind;
      logic [FIELD_OFFSET_W-1:0] field_offset;
      logic [7:0]                field_length;
      logic [1:0]                status;
      logic                      last_result;
   } rsp_item_type;

   typedef struct packed {
      logic         field_vld;
      logic         status_vld;
      rsp_item_type field_rec;
      rsp_item_type status_rec;
   } result_push_type;

endpackage

FILE: hw/rtl/bech32_payload_tlv_parser_core.sv
// Byte-serial parser for the payload of a decoded nostr bech32 object. One payload byte is
// taken per cycle on req_ while the result queue has room; csr_data selects the object kind,
// and the user is to write it only while the block is idle; the block does not enforce it.
// Field items and, on the final byte, one status item leave on rsp_ in payload order; a
// final byte that also completes a field gives two items. Each byte runs through one parse
// stage between the input register and a four-entry result queue, which holds its results
// until taken; req_ready stays high every cycle while the queue has two free entries, which
// holds when results are taken as fast as they arrive.
module bech32_payload_tlv_parser_core #(
   parameter int MAX_FIELDS      = btlv_pkg::MAX_FIELDS_DEF,
   parameter int MAX_RELAY_COUNT = btlv_pkg::MAX_RELAY_COUNT_DEF,
   parameter int PAYLOAD_BYTES   = btlv_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  btlv_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output btlv_pkg::rsp_item_type rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_data
);
   import btlv_pkg::*;

   logic            in_vld_ff, in_vld_in;
   req_item_type    in_item_ff;
   logic [2:0]      kind_ff;
   logic            advance;
   logic            space_ok;
   result_push_type push;

   assign csr_ready = 1'b1;
   assign advance   = in_vld_ff && space_ok;
   assign req_ready = !in_vld_ff || advance;
   assign in_vld_in = req_valid || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         kind_ff   <= KIND_NOTE;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_valid && csr_ready) begin
            kind_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
   end

   btlv_parser #(
      .MAX_FIELDS      (MAX_FIELDS),
      .MAX_RELAY_COUNT (MAX_RELAY_COUNT),
      .PAYLOAD_BYTES   (PAYLOAD_BYTES)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .kind    (kind_ff),
      .push    (push)
   );

   btlv_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule

FILE: hw/rtl/btlv_parser.sv
module btlv_parser #(
   parameter int MAX_FIELDS      = btlv_pkg::MAX_FIELDS_DEF,
   parameter int MAX_RELAY_COUNT = btlv_pkg::MAX_RELAY_COUNT_DEF,
   parameter int PAYLOAD_BYTES   = btlv_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  btlv_pkg::req_item_type    item,
   input  logic [2:0]                kind,
   output btlv_pkg::result_push_type push
);
   import btlv_pkg::*;

   localparam int POS_W   = $clog2(PAYLOAD_BYTES);
   localparam int DIFF_W  = (POS_W + 1 > 8) ? POS_W + 1 : 8;
   localparam int TLV_W   = $clog2(MAX_FIELDS + 1);
   localparam int RELAY_W = $clog2(MAX_RELAY_COUNT + 1);

   phase_type          phase_ff, phase_in;
   logic [7:0]         type_ff, type_in;
   logic [7:0]         rem_ff, rem_in;
   logic [POS_W:0]     vs_ff, vs_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [TLV_W-1:0]   tlv_ff, tlv_in;
   logic [RELAY_W-1:0] relay_ff, relay_in;
   logic               seen_ff, seen_in;
   logic [1:0]         err_ff, err_in;
   logic               stop_ff, stop_in;

   logic [7:0]                b;
   logic                      fin;
   logic [POS_W:0]            pos_p1;
   logic [POS_W:0]            vs_sel;
   logic [DIFF_W-1:0]         diff;
   logic [7:0]                tlv_len;
   logic [FIELD_OFFSET_W-1:0] tlv_off;

   logic       need32;
   logic       known;
   logic       required;
   logic       is_relay;
   logic [2:0] tlv_fk;
   logic [2:0] plain_fk;

   logic                      finish;
   logic                      fld_vld;
   logic [2:0]                fld_kind;
   logic [7:0]                fld_len;
   logic [FIELD_OFFSET_W-1:0] fld_off;
   logic [1:0]                st;

   assign b      = item.data_byte;
   assign fin    = item.final_byte;
   assign pos_p1 = (POS_W + 1)'(pos_ff) + 1'b1;
   assign vs_sel = (phase_ff == PH_LEN) ? pos_p1 : vs_ff;
   assign diff   = DIFF_W'(pos_p1) - DIFF_W'(vs_sel);
   assign tlv_len = diff[7:0];
   assign tlv_off = (vs_sel > (POS_W + 1)'(PAYLOAD_BYTES - 1))
                  ? FIELD_OFFSET_W'(PAYLOAD_BYTES - 1) : FIELD_OFFSET_W'(vs_sel);

   always_comb begin
      unique case (kind)
         KIND_NPUB: plain_fk = FK_PUBKEY;
         KIND_NSEC: plain_fk = FK_SECRET_KEY;
         default:   plain_fk = FK_EVENT_ID;
      endcase
   end

   always_comb begin
      need32   = 1'b0;
      known    = 1'b0;
      required = 1'b0;
      is_relay = 1'b0;
      tlv_fk   = FK_EVENT_ID;
      unique case (kind)
         KIND_NEVENT: begin
            if (type_ff == TAG_PRIMARY) begin
               need32 = 1'b1; known = 1'b1; required = 1'b1; tlv_fk = FK_EVENT_ID;
            end else if (type_ff == TAG_AUTHOR) begin
               need32 = 1'b1; known = 1'b1; tlv_fk = FK_PUBKEY;
            end else if (type_ff == TAG_RELAY) begin
               is_relay = 1'b1;
            end
         end
         KIND_NPROFILE: begin
            if (type_ff == TAG_PRIMARY) begin
               need32 = 1'b1; known = 1'b1; required = 1'b1; tlv_fk = FK_PUBKEY;
            end else if (type_ff == TAG_RELAY) begin
               is_relay = 1'b1;
            end
         end
         KIND_NADDR: begin
            if (type_ff == TAG_PRIMARY) begin
               known = 1'b1; required = 1'b1; tlv_fk = FK_IDENTIFIER;
            end else if (type_ff == TAG_AUTHOR) begin
               need32 = 1'b1; known = 1'b1; tlv_fk = FK_PUBKEY;
            end else if (type_ff == TAG_RELAY) begin
               is_relay = 1'b1;
            end
         end
         KIND_NRELAY: begin
            if (type_ff == TAG_PRIMARY) begin
               known = 1'b1; required = 1'b1; tlv_fk = FK_RELAY;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      type_in  = type_ff;
      rem_in   = rem_ff;
      vs_in    = vs_ff;
      tlv_in   = tlv_ff;
      relay_in = relay_ff;
      seen_in  = seen_ff;
      err_in   = err_ff;
      stop_in  = stop_ff;
      finish   = 1'b0;
      fld_vld  = 1'b0;
      fld_kind = FK_EVENT_ID;
      fld_len  = '0;
      fld_off  = '0;
      if (!stop_ff) begin
         case (kind) inside
            KIND_NOTE, KIND_NPUB, KIND_NSEC: begin
               if (pos_ff == POS_W'(KEY_BYTES - 1)) begin
                  fld_vld  = 1'b1;
                  fld_kind = plain_fk;
                  fld_len  = 8'(KEY_BYTES);
                  seen_in  = 1'b1;
                  stop_in  = 1'b1;
               end
            end
            KIND_NPROFILE, KIND_NEVENT, KIND_NRELAY, KIND_NADDR: begin
               unique case (phase_ff)
                  PH_TYPE: begin
                     type_in  = b;
                     phase_in = PH_LEN;
                  end
                  PH_LEN: begin
                     rem_in = b;
                     vs_in  = pos_p1;
                     if (b == 8'd0) begin
                        finish = 1'b1;
                     end else begin
                        phase_in = PH_VAL;
                     end
                  end
                  PH_VAL: begin
                     rem_in = rem_ff - 8'd1;
                     if (rem_in == 8'd0) begin
                        finish = 1'b1;
                     end
                  end
                  default: phase_in = PH_TYPE;
               endcase
               if (finish) begin
                  tlv_in   = tlv_ff + 1'b1;
                  phase_in = PH_TYPE;
                  if (need32 && tlv_len != 8'(KEY_BYTES)) begin
                     err_in  = ST_BAD_LEN;
                     stop_in = 1'b1;
                  end else begin
                     if (is_relay) begin
                        if (relay_ff < RELAY_W'(MAX_RELAY_COUNT)) begin
                           fld_vld  = 1'b1;
                           fld_kind = FK_RELAY;
                           relay_in = relay_ff + 1'b1;
                        end
                     end else if (known) begin
                        fld_vld  = 1'b1;
                        fld_kind = tlv_fk;
                        seen_in  = seen_ff | required;
                     end
                     fld_len = tlv_len;
                     fld_off = tlv_off;
                     if (tlv_in >= TLV_W'(MAX_FIELDS)) begin
                        stop_in = 1'b1;
                     end
                  end
               end
            end
            default: ;
         endcase
         if (!stop_in && !fin && pos_ff == POS_W'(PAYLOAD_BYTES - 1)) begin
            err_in  = ST_TRUNC;
            stop_in = 1'b1;
         end
      end

      pos_in = (pos_ff != POS_W'(PAYLOAD_BYTES - 1)) ? pos_ff + 1'b1 : pos_ff;

      if (err_in != ST_OK) begin
         st = err_in;
      end else begin
         case (kind) inside
            KIND_NOTE, KIND_NPUB, KIND_NSEC: st = seen_in ? ST_OK : ST_TRUNC;
            KIND_UNKNOWN:                    st = ST_MISSING;
            default: begin
               if (phase_in != PH_TYPE) begin
                  st = ST_TRUNC;
               end else if (!seen_in) begin
                  st = ST_MISSING;
               end else begin
                  st = ST_OK;
               end
            end
         endcase
      end

      if (fin) begin
         phase_in = PH_TYPE;
         type_in  = '0;
         rem_in   = '0;
         vs_in    = '0;
         pos_in   = '0;
         tlv_in   = '0;
         relay_in = '0;
         seen_in  = 1'b0;
         err_in   = ST_OK;
         stop_in  = 1'b0;
      end
   end

   always_comb begin
      push.field_vld  = advance && fld_vld;
      push.status_vld = advance && fin;
      push.field_rec  = '{result_kind: RK_FIELD, field_kind: fld_kind, field_offset: fld_off,
                          field_length: fld_len, status: ST_OK, last_result: 1'b0};
      push.status_rec = '{result_kind: RK_STATUS, field_kind: FK_EVENT_ID, field_offset: '0,
                          field_length: 8'd0, status: st, last_result: 1'b1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
      end else if (advance) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff  <= '0;
         rem_ff   <= '0;
         vs_ff    <= '0;
         pos_ff   <= '0;
         tlv_ff   <= '0;
         relay_ff <= '0;
         seen_ff  <= 1'b0;
         err_ff   <= ST_OK;
         stop_ff  <= 1'b0;
      end else if (advance) begin
         type_ff  <= type_in;
         rem_ff   <= rem_in;
         vs_ff    <= vs_in;
         pos_ff   <= pos_in;
         tlv_ff   <= tlv_in;
         relay_ff <= relay_in;
         seen_ff  <= seen_in;
         err_ff   <= err_in;
         stop_ff  <= stop_in;
      end
   end

`ifndef SYNTHESIS
   a_no_field_when_stopped: assert property (@(posedge clock) disable iff (reset)
      (stop_ff && advance) |-> !push.field_vld)
      else $error("field item emitted after parsing stopped");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && fin) |=> (pos_ff == '0 && phase_ff == PH_TYPE && !stop_ff))
      else $error("payload state not cleared after final byte");
`endif

endmodule

FILE: hw/rtl/btlv_result_queue.sv
module btlv_result_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  btlv_pkg::result_push_type push,
   output logic                      space_ok,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output btlv_pkg::rsp_item_type    rsp_item
);
   import btlv_pkg::*;

   localparam int AW    = $clog2(RQ_DEPTH);
   localparam int CNT_W = AW + 1;

   rsp_item_type     q_ff [RQ_DEPTH];
   logic [AW-1:0]    wr_ff, wr_in;
   logic [AW-1:0]    rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   rsp_item_type first_rec;
   logic         first_vld;
   logic         second_vld;
   logic         pop;
   logic [1:0]   n_push;

   assign first_rec  = push.field_vld ? push.field_rec : push.status_rec;
   assign first_vld  = push.field_vld | push.status_vld;
   assign second_vld = push.field_vld & push.status_vld;
   assign n_push     = 2'(first_vld) + 2'(second_vld);

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_item  = q_ff[rd_ff];
   assign pop       = rsp_valid && rsp_ready;
   assign space_ok  = (cnt_ff <= CNT_W'(RQ_DEPTH - 2));

   assign wr_in  = wr_ff + AW'(n_push);
   assign rd_in  = rd_ff + AW'(pop);
   assign cnt_in = cnt_ff + CNT_W'(n_push) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (first_vld) begin
         q_ff[wr_ff] <= first_rec;
      end
      if (second_vld) begin
         q_ff[wr_ff + 1'b1] <= push.status_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RQ_DEPTH))
      else $error("result queue overflow");

   a_double_push: assert property (@(posedge clock) disable iff (reset)
      (second_vld && !pop) |=> cnt_ff == $past(cnt_ff) + CNT_W'(2))
      else $error("result queue lost an item on double push");
`endif

endmodule
